### rtl/ggpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggpc_pkg
// Types, constants and tables shared by the go-to-goal controller modules.
// ----------------------------------------------------------------------------
package ggpc_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 13;

    localparam int STEP_W  = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int X_W     = 36;
    localparam int Z_W     = 34;
    localparam int MAG_W   = 35;
    localparam int BEAR_W  = ANGLE_FRAC_BITS + 4;
    localparam int ERR_W   = ((BEAR_W > 16) ? BEAR_W : 16) + 2;
    localparam int MUL_A_W = (ERR_W > 33) ? ERR_W : 33;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;
    localparam int HI_W    = (MAG_W - 16) + MUL_B_W;
    localparam int SUM_W   = HI_W + 1;
    localparam int ANG_SH_W = PROD_W - 8;

    localparam int DATA_W     = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int S_TDATA_W  = 88;
    localparam int M_TDATA_W  = 80;
    localparam int M_TUSER_W  = 2;

    localparam longint PI_Q30_L     = 64'sd3373259426;
    localparam longint TWO_PI_Q30_L = 64'sd6746518852;
    localparam longint ROUND_Q30_L  = 64'sd1 <<< (29 - ANGLE_FRAC_BITS);
    localparam longint PI_ANG_L     = (PI_Q30_L + ROUND_Q30_L) >>> (30 - ANGLE_FRAC_BITS);
    localparam longint TWO_PI_ANG_L = (TWO_PI_Q30_L + ROUND_Q30_L) >>> (30 - ANGLE_FRAC_BITS);

    localparam logic signed [Z_W-1:0]   HALF_PI_Q30 = Z_W'(64'sd1686629713);
    localparam logic signed [Z_W-1:0]   ANG_ROUND   = Z_W'(ROUND_Q30_L);
    localparam logic signed [ERR_W-1:0] PI_ANG      = ERR_W'(PI_ANG_L);
    localparam logic signed [ERR_W-1:0] NEG_PI_ANG  = ERR_W'(-PI_ANG_L);
    localparam logic signed [ERR_W-1:0] TWO_PI_ANG  = ERR_W'(TWO_PI_ANG_L);
    localparam logic [MUL_B_W-1:0]      INV_GAIN_Q32 = 32'h9B74EDA8;

    localparam logic signed [ANG_SH_W-1:0] ANG_MAX = ANG_SH_W'(32767);
    localparam logic signed [ANG_SH_W-1:0] ANG_MIN = ANG_SH_W'(-32768);

    localparam logic [31:0] GOAL_RESET       = 32'd0;
    localparam logic [15:0] RADIUS_RESET     = 16'd6554;
    localparam logic [15:0] MAX_LINEAR_RESET = 16'd13107;
    localparam logic [15:0] GAIN_RESET       = 16'd128;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_GOAL_X         = 3'd0,
        CFG_GOAL_Y         = 3'd1,
        CFG_ARRIVAL_RADIUS = 3'd2,
        CFG_MAX_LINEAR     = 3'd3,
        CFG_LINEAR_GAIN    = 3'd4,
        CFG_ANGULAR_GAIN   = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        RUN_DRIVING  = 2'd0,
        RUN_REACHED  = 2'd1,
        RUN_CANCELED = 2'd2,
        RUN_IDLE     = 2'd3
    } run_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_MAG_HI,
        ST_MAG_LO,
        ST_MAG_SUM,
        ST_DECIDE,
        ST_WRAP,
        ST_LIN,
        ST_ANG,
        ST_ANG_SAT,
        ST_OUT
    } seq_state_t;

    typedef struct packed {
        logic                     done;
        logic [MAG_W-1:0]         mag;
        logic signed [BEAR_W-1:0] bearing;
    } cordic_res_t;

    function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:  v = Z_W'(843314857);
            5'd1:  v = Z_W'(497837829);
            5'd2:  v = Z_W'(263043837);
            5'd3:  v = Z_W'(133525159);
            5'd4:  v = Z_W'(67021687);
            5'd5:  v = Z_W'(33543516);
            5'd6:  v = Z_W'(16775851);
            5'd7:  v = Z_W'(8388437);
            5'd8:  v = Z_W'(4194283);
            5'd9:  v = Z_W'(2097149);
            5'd10: v = Z_W'(1048576);
            5'd11: v = Z_W'(524288);
            5'd12: v = Z_W'(262144);
            5'd13: v = Z_W'(131072);
            5'd14: v = Z_W'(65536);
            5'd15: v = Z_W'(32768);
            5'd16: v = Z_W'(16384);
            5'd17: v = Z_W'(8192);
            5'd18: v = Z_W'(4096);
            5'd19: v = Z_W'(2048);
            5'd20: v = Z_W'(1024);
            5'd21: v = Z_W'(512);
            5'd22: v = Z_W'(256);
            5'd23: v = Z_W'(128);
            5'd24: v = Z_W'(64);
            5'd25: v = Z_W'(32);
            5'd26: v = Z_W'(16);
            5'd27: v = Z_W'(8);
            5'd28: v = Z_W'(4);
            5'd29: v = Z_W'(2);
            5'd30: v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/ggpc_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggpc_cordic
// Iterative vectoring CORDIC: one micro-rotation per cycle on a shared
// shift-add stage, giving the offset magnitude and its bearing.
// ----------------------------------------------------------------------------
module ggpc_cordic
    import ggpc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [32:0] dx,
    input  logic signed [32:0] dy,
    output cordic_res_t        res
);

    logic                     busy_reg;
    logic                     done_reg;
    logic [STEP_W-1:0]        step_reg;
    logic signed [X_W-1:0]    x_reg;
    logic signed [X_W-1:0]    y_reg;
    logic signed [Z_W-1:0]    z_reg;
    logic                     zero_reg;

    logic signed [X_W-1:0]    dx_ext;
    logic signed [X_W-1:0]    dy_ext;
    logic signed [X_W-1:0]    xs;
    logic signed [X_W-1:0]    ys;
    logic signed [Z_W-1:0]    atan_step;
    logic signed [Z_W-1:0]    z_round;

    assign dx_ext    = X_W'(dx);
    assign dy_ext    = X_W'(dy);
    assign xs        = x_reg >>> step_reg;
    assign ys        = y_reg >>> step_reg;
    assign atan_step = atan_q30(5'(step_reg));
    assign z_round   = z_reg + ANG_ROUND;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                if (step_reg == STEP_W'(CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            zero_reg <= (dx == '0) && (dy == '0);
            if (dx < 0) begin
                if (dy >= 0) begin
                    x_reg <= dy_ext;
                    y_reg <= -dx_ext;
                    z_reg <= HALF_PI_Q30;
                end else begin
                    x_reg <= -dy_ext;
                    y_reg <= dx_ext;
                    z_reg <= -HALF_PI_Q30;
                end
            end else begin
                x_reg <= dx_ext;
                y_reg <= dy_ext;
                z_reg <= '0;
            end
        end else if (busy_reg) begin
            if (!y_reg[X_W-1]) begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_step;
            end else begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_step;
            end
        end
    end

    always_comb begin
        res.done    = done_reg;
        res.mag     = x_reg[X_W-1] ? '0 : x_reg[MAG_W-1:0];
        res.bearing = zero_reg ? '0 : z_round[Z_W-1:30-ANGLE_FRAC_BITS];
    end

endmodule

### rtl/ggpc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggpc_mul
// Shared registered multiplier: signed operand times unsigned operand.
// ----------------------------------------------------------------------------
module ggpc_mul
    import ggpc_pkg::*;
(
    input  logic                      aclk,
    input  logic signed [MUL_A_W-1:0] op_a,
    input  logic [MUL_B_W-1:0]        op_b,
    output logic signed [PROD_W-1:0]  prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(op_a * $signed({1'b0, op_b}));
    end

    assign prod = prod_reg;

endmodule

### rtl/go_to_goal_p_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_to_goal_p_controller
// Proportional go-to-goal controller: distance, heading error and commands.
// ----------------------------------------------------------------------------
// Each input item is one control tick carrying pos_x, pos_y, heading and
// cancel_request; each tick yields exactly one result item with linear_cmd,
// angular_cmd, distance_left, elapsed_ticks and run_status.
// The goal and tuning values are written through the cfg_* port while the
// block is idle, which the user must keep to, as the block does not enforce
// it; writing goal_x or goal_y starts a new run. A tick runs the CORDIC
// loop of 16 steps, the distance scaling and the decision and, for driving
// ticks, the heading wrap and the commands; the single shared multiplier
// forms the four products in turn. One tick is in work at a time; the
// next item is accepted in the cycle after the result is loaded.
// The result sits in an output register, so a new item is accepted while a
// result waits; if the receiver stalls, the following result waits at the
// end of its sequence until the register is free.
// Reset restores the register defaults, clears the run state and the tick
// count, and empties the output register.
// ----------------------------------------------------------------------------
module go_to_goal_p_controller
    import ggpc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // pos_x[31:0], pos_y[63:32], heading[79:64], cancel_request[80], zero pad
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // linear_cmd[15:0], angular_cmd[31:16], distance_left[63:32],
    // elapsed_ticks[79:64]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // run_status[1:0]
    output logic [M_TUSER_W-1:0]  m_tuser,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [DATA_W-1:0]     cfg_wr_data
);

    seq_state_t state_reg, state_next;

    logic signed [31:0]       goal_x_reg;
    logic signed [31:0]       goal_y_reg;
    logic [15:0]              radius_reg;
    logic [15:0]              max_linear_reg;
    logic [15:0]              linear_gain_reg;
    logic [15:0]              angular_gain_reg;
    logic                     finished_reg;
    logic [15:0]              tick_reg;

    logic signed [15:0]       heading_reg;
    logic                     cancel_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic [HI_W-1:0]          hi_reg;
    logic [31:0]              dist_reg;
    logic [15:0]              elapsed_reg;
    run_status_t              status_reg;
    logic [15:0]              lin_reg;
    logic [15:0]              ang_reg;

    logic                     m_tvalid_reg;
    logic [M_TDATA_W-1:0]     m_tdata_reg;
    logic [M_TUSER_W-1:0]     m_tuser_reg;

    logic signed [31:0]       pos_x;
    logic signed [31:0]       pos_y;
    logic signed [32:0]       dx;
    logic signed [32:0]       dy;
    logic                     accept;
    logic                     out_free;
    logic                     cordic_start;
    cordic_res_t              cres;

    logic signed [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic signed [PROD_W-1:0]  prod;

    logic [SUM_W-1:0]          mag_sum;
    logic [39:0]               lin_full;
    logic signed [ANG_SH_W-1:0] ang_sh;
    logic                      driving;

    assign pos_x    = s_tdata[31:0];
    assign pos_y    = s_tdata[63:32];
    assign dx       = 33'(goal_x_reg) - 33'(pos_x);
    assign dy       = 33'(goal_y_reg) - 33'(pos_y);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign mag_sum  = {1'b0, hi_reg} + SUM_W'(prod[47:16]);
    assign lin_full = prod[47:8];
    assign ang_sh   = prod[PROD_W-1:8];
    assign driving  = !finished_reg && !cancel_reg && (dist_reg >= 32'(radius_reg));

    ggpc_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .dx      (dx),
        .dy      (dy),
        .res     (cres)
    );

    ggpc_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (accept) state_next = ST_CORDIC;
            ST_CORDIC:  if (cres.done) state_next = ST_MAG_HI;
            ST_MAG_HI:  state_next = ST_MAG_LO;
            ST_MAG_LO:  state_next = ST_MAG_SUM;
            ST_MAG_SUM: state_next = ST_DECIDE;
            ST_DECIDE:  state_next = driving ? ST_WRAP : ST_OUT;
            ST_WRAP: begin
                if ((err_reg <= PI_ANG) && (err_reg >= NEG_PI_ANG)) begin
                    state_next = ST_LIN;
                end
            end
            ST_LIN:     state_next = ST_ANG;
            ST_ANG:     state_next = ST_ANG_SAT;
            ST_ANG_SAT: state_next = ST_OUT;
            ST_OUT:     if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = (state_reg == ST_IDLE);
        cordic_start = s_tvalid && (state_reg == ST_IDLE);
        mul_a        = '0;
        mul_b        = '0;
        case (state_reg)
            ST_MAG_HI: begin
                mul_a = MUL_A_W'(mag_reg[MAG_W-1:16]);
                mul_b = INV_GAIN_Q32;
            end
            ST_MAG_LO: begin
                mul_a = MUL_A_W'(mag_reg[15:0]);
                mul_b = INV_GAIN_Q32;
            end
            ST_LIN: begin
                mul_a = MUL_A_W'(dist_reg);
                mul_b = MUL_B_W'(linear_gain_reg);
            end
            ST_ANG: begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = MUL_B_W'(angular_gain_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration writes and the run state. A goal write starts a new run.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            goal_x_reg       <= GOAL_RESET;
            goal_y_reg       <= GOAL_RESET;
            radius_reg       <= RADIUS_RESET;
            max_linear_reg   <= MAX_LINEAR_RESET;
            linear_gain_reg  <= GAIN_RESET;
            angular_gain_reg <= GAIN_RESET;
            finished_reg     <= 1'b0;
            tick_reg         <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_GOAL_X: begin
                    goal_x_reg   <= cfg_wr_data;
                    finished_reg <= 1'b0;
                    tick_reg     <= '0;
                end
                CFG_GOAL_Y: begin
                    goal_y_reg   <= cfg_wr_data;
                    finished_reg <= 1'b0;
                    tick_reg     <= '0;
                end
                CFG_ARRIVAL_RADIUS: radius_reg       <= cfg_wr_data[15:0];
                CFG_MAX_LINEAR:     max_linear_reg   <= cfg_wr_data[15:0];
                CFG_LINEAR_GAIN:    linear_gain_reg  <= cfg_wr_data[15:0];
                CFG_ANGULAR_GAIN:   angular_gain_reg <= cfg_wr_data[15:0];
                default: ;
            endcase
        end else if (state_reg == ST_DECIDE) begin
            if (!finished_reg && (cancel_reg || !driving)) begin
                finished_reg <= 1'b1;
            end
            if (driving && (tick_reg != 16'hFFFF)) begin
                tick_reg <= tick_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    heading_reg <= s_tdata[79:64];
                    cancel_reg  <= s_tdata[80];
                end
            end
            ST_CORDIC: begin
                if (cres.done) begin
                    mag_reg <= cres.mag;
                    err_reg <= ERR_W'($signed(cres.bearing)) - ERR_W'(heading_reg);
                end
            end
            ST_MAG_LO: hi_reg <= prod[HI_W-1:0];
            ST_MAG_SUM: begin
                if (mag_sum[SUM_W-1:48] != '0) begin
                    dist_reg <= 32'hFFFF_FFFF;
                end else begin
                    dist_reg <= mag_sum[47:16];
                end
            end
            ST_DECIDE: begin
                elapsed_reg <= tick_reg;
                lin_reg     <= '0;
                ang_reg     <= '0;
                if (finished_reg) begin
                    status_reg <= RUN_IDLE;
                end else if (cancel_reg) begin
                    status_reg <= RUN_CANCELED;
                end else if (!driving) begin
                    status_reg <= RUN_REACHED;
                end else begin
                    status_reg <= RUN_DRIVING;
                end
            end
            ST_WRAP: begin
                if (err_reg > PI_ANG) begin
                    err_reg <= err_reg - TWO_PI_ANG;
                end else if (err_reg < NEG_PI_ANG) begin
                    err_reg <= err_reg + TWO_PI_ANG;
                end
            end
            ST_ANG: begin
                if (lin_full > 40'(max_linear_reg)) begin
                    lin_reg <= max_linear_reg;
                end else begin
                    lin_reg <= lin_full[15:0];
                end
            end
            ST_ANG_SAT: begin
                if (ang_sh > ANG_MAX) begin
                    ang_reg <= 16'h7FFF;
                end else if (ang_sh < ANG_MIN) begin
                    ang_reg <= 16'h8000;
                end else begin
                    ang_reg <= ang_sh[15:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if ((state_reg == ST_OUT) && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_OUT) && out_free) begin
            m_tdata_reg <= {elapsed_reg, dist_reg, ang_reg, lin_reg};
            m_tuser_reg <= status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### rtl/ggpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggpc_checker
// Port-level assertions for the go-to-goal controller, bound to the top.
// ----------------------------------------------------------------------------
module ggpc_checker
    import ggpc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // A tick in work blocks the input until its result is issued.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a tick is in work");

    // A new result appears only as the sequencer returns to idle.
    a_ready_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result issued while the sequencer is busy");

    // Ending and idle ticks carry zero speed commands.
    a_zero_cmds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != RUN_DRIVING)) |-> (m_tdata[31:0] == '0))
        else $error("nonzero command outside a driving tick");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result item changed");

endmodule

bind go_to_goal_p_controller ggpc_checker u_ggpc_checker (.*);

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the go-to-goal proportional controller.
// ----------------------------------------------------------------------------
// Control ticks go in on the slave stream and results come back on the master
// stream. A tracker class mirrors the goal registers, the run state and the
// tick counter. It runs its own CORDIC in vectoring mode to predict the
// distance, the status and the speed commands of every accepted tick. Each
// result item is compared field by field with the oldest prediction.
// A short directed part covers the register extremes, the first three quadrants, the
// cancel, arrival, idle and heading wrap cases and writes to unmapped
// register indexes. After it come random goal runs under three patterns of
// stream back-pressure, one of them with a long receiver stall.
// ----------------------------------------------------------------------------
module tb;
    import ggpc_pkg::*;

    localparam int RANDOM_TICKS  = 950;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 64;
    localparam longint TIMEOUT_NS = 64'd6_000_000;

    localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED_HI = 3'd7;

    localparam logic signed [15:0] HEADING_LIMIT = 16'sd25736;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint unsigned INV_GAIN = 64'd2608131496;
    localparam longint ATAN_Q30 [32] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
        131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
        128, 64, 32, 16, 8, 4, 2, 1, 0
    };

    typedef struct {
        logic [15:0]        lin;
        logic signed [15:0] ang;
        logic [31:0]        span;
        logic [15:0]        ticks;
        run_status_t        status;
    } tick_result_t;

    class goal_tracker;
        logic signed [31:0] goal_x, goal_y;
        logic [15:0]        radius, lin_cap, lin_gain, ang_gain;
        bit                 finished;
        logic [15:0]        ticks;
        tick_result_t       awaited_results[$];
        int                 errors;

        function new();
            goal_x   = '0;
            goal_y   = '0;
            radius   = 16'd6554;
            lin_cap  = 16'd13107;
            lin_gain = 16'd128;
            ang_gain = 16'd128;
            finished = 1'b0;
            ticks    = '0;
            errors   = 0;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_GOAL_X: begin
                    goal_x   = data;
                    finished = 1'b0;
                    ticks    = '0;
                end
                CFG_GOAL_Y: begin
                    goal_y   = data;
                    finished = 1'b0;
                    ticks    = '0;
                end
                CFG_ARRIVAL_RADIUS: radius   = data[15:0];
                CFG_MAX_LINEAR:     lin_cap  = data[15:0];
                CFG_LINEAR_GAIN:    lin_gain = data[15:0];
                CFG_ANGULAR_GAIN:   ang_gain = data[15:0];
                default: ;
            endcase
        endfunction

        function longint to_angle(longint v);
            return (v + (longint'(1) <<< (29 - ANGLE_FRAC_BITS))) >>> (30 - ANGLE_FRAC_BITS);
        endfunction

        function void vector_offset(longint dx, longint dy,
                                    output longint unsigned span,
                                    output longint bearing);
            longint x, y, z, t, xs, ys;
            longint unsigned ux, hi, lo, d;
            x = dx;
            y = dy;
            z = 0;
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y;
                    y = -t;
                    z = HALF_PI_Q30;
                end else begin
                    x = -y;
                    y = t;
                    z = -HALF_PI_Q30;
                end
            end
            for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_Q30[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_Q30[i];
                end
            end
            ux = (x < 0) ? 64'd0 : x;
            hi = (ux >> 16) * INV_GAIN;
            lo = (ux & 64'hFFFF) * INV_GAIN;
            d = (hi + (lo >> 16)) >> 16;
            span = (d > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : d;
            bearing = (dx == 0 && dy == 0) ? 0 : to_angle(z);
        endfunction

        function void note_tick(logic signed [31:0] px, logic signed [31:0] py,
                                logic signed [15:0] hd, logic cancel);
            longint unsigned span, lin_full;
            longint bearing, err, ang, pi_a, two_pi_a;
            tick_result_t r;
            vector_offset(longint'(goal_x) - longint'(px), longint'(goal_y) - longint'(py),
                          span, bearing);
            r.span  = span[31:0];
            r.ticks = ticks;
            r.lin   = '0;
            r.ang   = '0;
            if (finished) begin
                r.status = RUN_IDLE;
            end else if (cancel) begin
                r.status = RUN_CANCELED;
                finished = 1'b1;
            end else if (span < radius) begin
                r.status = RUN_REACHED;
                finished = 1'b1;
            end else begin
                pi_a = to_angle(PI_Q30);
                two_pi_a = to_angle(2 * PI_Q30);
                err = bearing - longint'(hd);
                if (err > pi_a) begin
                    err = err - ((err - pi_a - 1) / two_pi_a + 1) * two_pi_a;
                end else if (err < -pi_a) begin
                    err = err + ((-pi_a - err - 1) / two_pi_a + 1) * two_pi_a;
                end
                lin_full = (span * lin_gain) >> 8;
                r.lin = (lin_full > lin_cap) ? lin_cap : lin_full[15:0];
                ang = (err * longint'(ang_gain)) >>> 8;
                if (ang > 32767) ang = 32767;
                if (ang < -32768) ang = -32768;
                r.ang = ang[15:0];
                r.status = RUN_DRIVING;
                if (ticks != 16'hFFFF) ticks = ticks + 16'd1;
            end
            awaited_results.push_back(r);
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data, logic [M_TUSER_W-1:0] user);
            tick_result_t exp_r;
            if (awaited_results.size() == 0) begin
                $error("result item arrived with no tick waiting for it");
                errors++;
                return;
            end
            exp_r = awaited_results.pop_front();
            compare_field("linear_cmd", longint'(exp_r.lin), longint'(data[15:0]));
            compare_field("angular_cmd", longint'(exp_r.ang), longint'($signed(data[31:16])));
            compare_field("distance_left", longint'(exp_r.span), longint'(data[63:32]));
            compare_field("elapsed_ticks", longint'(exp_r.ticks), longint'(data[79:64]));
            compare_field("run_status", longint'(exp_r.status), longint'(user));
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // pos_x[31:0], pos_y[63:32], heading[79:64], cancel_request[80], zero pad
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // linear_cmd[15:0], angular_cmd[31:16], distance_left[63:32],
    // elapsed_ticks[79:64]
    logic [M_TDATA_W-1:0]  m_tdata;
    // run_status[1:0]
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [DATA_W-1:0]     cfg_wr_data;

    goal_tracker tracker = new();

    int send_gap_pct = 0;
    int recv_gap_pct = 0;
    int random_ticks = 0;
    bit hold_request = 1'b0;
    int hold_left = 0;

    go_to_goal_p_controller dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                tracker.check_result(m_tdata, m_tuser);
            end
            if (hold_request) begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_gap_pct);
            end
        end
    end

    // The enable stays high between back-to-back writes; the next tick lowers it.
    task automatic set_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        tracker.write_reg(idx, data);
    endtask

    task automatic send_tick(input logic [31:0] px, input logic [31:0] py,
                             input logic [15:0] hd, input logic cancel);
        cfg_wr_en <= 1'b0;
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({cancel, hd, py, px});
        do @(posedge aclk); while (!s_tready);
        tracker.note_tick($signed(px), $signed(py), $signed(hd), cancel);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_u16_word();
        logic [15:0] v;
        case ($urandom_range(4))
            0: v = 16'h0000;
            1: v = 16'hFFFF;
            2: v = 16'($urandom_range(1, 1023));
            default: v = 16'($urandom());
        endcase
        return {16'($urandom()), v};
    endfunction

    function automatic logic [31:0] rand_goal();
        logic signed [31:0] v;
        v = $urandom();
        case ($urandom_range(9))
            0: v = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1, 2: ;
            default: v = v >>> 7;
        endcase
        return v;
    endfunction

    task automatic random_run(input bit squeeze);
        int n_ticks, shift, pick, sel;
        logic signed [31:0] off_x, off_y;
        logic [31:0] px, py;
        logic [15:0] hd;
        wait_idle();
        if ($urandom_range(2) == 0) set_reg(CFG_ARRIVAL_RADIUS, rand_u16_word());
        if ($urandom_range(2) == 0) set_reg(CFG_MAX_LINEAR, rand_u16_word());
        if ($urandom_range(2) == 0) set_reg(CFG_LINEAR_GAIN, rand_u16_word());
        if ($urandom_range(2) == 0) set_reg(CFG_ANGULAR_GAIN, rand_u16_word());
        if ($urandom_range(15) == 0) begin
            set_reg($urandom_range(1) ? CFG_UNMAPPED_LO : CFG_UNMAPPED_HI, $urandom());
        end
        sel = $urandom_range(2);
        if (sel != 1) set_reg(CFG_GOAL_X, rand_goal());
        if (sel != 0) set_reg(CFG_GOAL_Y, rand_goal());
        if (squeeze) hold_request = 1'b1;
        n_ticks = squeeze ? 25 : $urandom_range(2, 30);
        repeat (n_ticks) begin
            pick  = $urandom_range(99);
            shift = (pick < 8) ? $urandom_range(0, 15) : $urandom_range(16, 31);
            off_x = $urandom();
            off_y = $urandom();
            off_x = off_x >>> (31 - shift);
            off_y = off_y >>> (31 - shift);
            px = tracker.goal_x - off_x;
            py = tracker.goal_y - off_y;
            if (pick >= 96) begin
                px = $urandom();
                py = $urandom();
            end
            if ($urandom_range(9) == 0) begin
                hd = 16'($urandom());
            end else begin
                hd = 16'(int'($urandom_range(2 * HEADING_LIMIT)) - HEADING_LIMIT);
            end
            send_tick(px, py, hd, pick < 3);
            random_ticks++;
        end
    endtask

    initial begin
        bit squeezed;
        squeezed    = 1'b0;
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= CFG_GOAL_X;
        cfg_wr_data <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // With the default goal at the origin the first tick arrives at once
        // and the second is idle, with its cancel ignored.
        send_tick(32'd0, 32'd0, 16'd0, 1'b0);
        send_tick(32'h0001_86A0, -32'sd5, 16'd0, 1'b1);
        wait_idle();

        // A zero radius keeps a zero offset driving, with the bearing taken as zero.
        set_reg(CFG_ARRIVAL_RADIUS, 32'hFFFF_0000);
        set_reg(CFG_GOAL_X, 32'd0);
        send_tick(32'd0, 32'd0, 16'd0, 1'b0);
        send_tick(32'h8000_0000, 32'h8000_0000, 16'h7FFF, 1'b0);
        wait_idle();

        set_reg(CFG_GOAL_X, 32'h7FFF_FFFF);
        set_reg(CFG_GOAL_Y, 32'h7FFF_FFFF);
        set_reg(CFG_MAX_LINEAR, 32'hA5A5_FFFF);
        set_reg(CFG_LINEAR_GAIN, 32'h5A5A_FFFF);
        set_reg(CFG_ANGULAR_GAIN, 32'h0F0F_FFFF);
        send_tick(32'h8000_0000, 32'h8000_0000, 16'h8000, 1'b0);
        send_tick(32'h7FFF_FFFF, 32'h8000_0000, HEADING_LIMIT, 1'b0);
        wait_idle();

        // Offsets in the left half plane, both signs of y and y at zero.
        set_reg(CFG_GOAL_X, 32'h8000_0000);
        set_reg(CFG_GOAL_Y, 32'd0);
        send_tick(32'h7FFF_FFFF, 32'd5, HEADING_LIMIT, 1'b0);
        send_tick(32'h7FFF_FFFF, -32'sd5, -HEADING_LIMIT, 1'b0);
        send_tick(32'h7FFF_FFFF, 32'd0, 16'd0, 1'b0);
        wait_idle();

        // Cancel and arrival in the same tick: the cancel wins.
        set_reg(CFG_ARRIVAL_RADIUS, 32'h0000_FFFF);
        set_reg(CFG_GOAL_X, 32'd0);
        send_tick(32'd0, 32'd0, 16'd0, 1'b1);
        send_tick(32'd0, 32'd0, 16'd0, 1'b1);
        send_tick(32'h0000_1000, 32'hFFFF_F000, 16'h1234, 1'b0);
        wait_idle();

        set_reg(CFG_MAX_LINEAR, 32'd0);
        set_reg(CFG_LINEAR_GAIN, 32'd0);
        set_reg(CFG_ANGULAR_GAIN, 32'd0);
        set_reg(CFG_GOAL_Y, 32'h1234_5678);
        set_reg(CFG_UNMAPPED_LO, 32'hFFFF_FFFF);
        set_reg(CFG_UNMAPPED_HI, 32'h0000_0001);
        send_tick(32'hFEDC_BA98, 32'h0101_0101, 16'h1234, 1'b0);
        send_tick(32'h0000_0000, 32'h0000_0000, 16'hC000, 1'b0);
        wait_idle();

        set_reg(CFG_ARRIVAL_RADIUS, 32'd6554);
        set_reg(CFG_MAX_LINEAR, 32'd13107);
        set_reg(CFG_LINEAR_GAIN, 32'd128);
        set_reg(CFG_ANGULAR_GAIN, 32'd128);

        while (random_ticks < RANDOM_TICKS) begin
            if (random_ticks < RANDOM_TICKS / 3) begin
                send_gap_pct = 18;
                recv_gap_pct = 62;
                random_run(1'b0);
            end else if (random_ticks < 2 * RANDOM_TICKS / 3) begin
                send_gap_pct = 62;
                recv_gap_pct = 18;
                random_run(1'b0);
            end else begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
                random_run(!squeezed);
                squeezed = 1'b1;
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/ggpc_pkg.sv
rtl/ggpc_cordic.sv
rtl/ggpc_mul.sv
rtl/go_to_goal_p_controller.sv
rtl/ggpc_checker.sv
tb/sv/tb.sv
